// ----- hw/rtl/jdf_pkg.sv -----
`timescale 1ns / 1ps
package jdf_pkg;

  localparam int DEF_MAX_X     = 128;
  localparam int DEF_MAX_Y     = 128;
  localparam int DEF_COMP_BITS = 16;

  localparam int FIELD_W  = 16;
  localparam int DET_W    = 52;
  localparam int SIZE_XW  = 8;
  localparam int SIZE_YW  = 8;
  localparam int SIZE_ZW  = 16;
  localparam int CFG_IDXW = 8;
  localparam int CFG_DW   = 16;

  localparam logic [SIZE_XW-1:0] RST_SIZE_X = 8'd128;
  localparam logic [SIZE_YW-1:0] RST_SIZE_Y = 8'd128;
  localparam logic [SIZE_ZW-1:0] RST_SIZE_Z = 16'd128;

  localparam logic [CFG_IDXW-1:0] CFG_SIZE_X = 8'd0;
  localparam logic [CFG_IDXW-1:0] CFG_SIZE_Y = 8'd1;
  localparam logic [CFG_IDXW-1:0] CFG_SIZE_Z = 8'd2;

endpackage

// ----- hw/rtl/jdf_channels.sv -----
`timescale 1ns / 1ps
interface jdf_voxel_if import jdf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] vector_x;
  logic signed [FIELD_W-1:0] vector_y;
  logic signed [FIELD_W-1:0] vector_z;
  modport source (output valid, vector_x, vector_y, vector_z, input ready);
  modport sink (input valid, vector_x, vector_y, vector_z, output ready);
endinterface

interface jdf_result_if import jdf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DET_W-1:0] determinant;
  logic                    last_of_volume;
  modport source (output valid, determinant, last_of_volume, input ready);
  modport sink (input valid, determinant, last_of_volume, output ready);
endinterface

interface jdf_cfg_if import jdf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CFG_IDXW-1:0] index;
  logic [CFG_DW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/jacobian_determinant_3d_field_unit.sv -----
`timescale 1ns / 1ps
// Streams a 3-component vector field in raster order (x fastest) and returns,
// one plane behind the input, the determinant of the unscaled central
// differences of each voxel (eight times the Jacobian determinant, Q.24,
// zero on the border). The first plane of a volume gives no results and the
// trailing border plane is not emitted. The window of two planes plus one
// voxel lives in a single-port-read memory, so an interior voxel takes five
// sequential neighbor reads followed by nine passes through one shared
// multiplier, with the input held not ready. A border voxel skips both and
// goes straight to the output register. A result waits in the output
// register while the sink stalls, and the next voxel that has a result waits
// behind it. A configuration write restarts the volume at the next voxel.
module jacobian_determinant_3d_field_unit import jdf_pkg::*; #(
  parameter int MAX_X = DEF_MAX_X,
  parameter int MAX_Y = DEF_MAX_Y,
  parameter int COMPONENT_BITS = DEF_COMP_BITS
) (
  input  logic   clk,
  input  logic   rst,
  jdf_voxel_if.sink    voxel,
  jdf_result_if.source result,
  jdf_cfg_if.sink      cfg
);

  localparam int CB    = COMPONENT_BITS;
  localparam int VW    = 3 * CB;
  localparam int DEPTH = 2 * MAX_X * MAX_Y + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int OW    = AW + 1;
  localparam int XW    = $clog2(MAX_X + 1);
  localparam int YW    = $clog2(MAX_Y + 1);
  localparam int CW    = $clog2(MAX_X);
  localparam int RW    = $clog2(MAX_Y);

  typedef enum logic [1:0] {S_IDLE, S_RD, S_CALC, S_OUT} state_t;

  state_t state;
  logic [SIZE_XW-1:0] size_x;
  logic [SIZE_YW-1:0] size_y;
  logic [SIZE_ZW-1:0] size_z;
  logic [XW-1:0] sx;
  logic [YW-1:0] sy;
  logic [SIZE_ZW-1:0] sz;
  logic [XW+YW-1:0] plane_prod;
  logic [OW-1:0] plane_q;
  logic [OW-1:0] sx_q;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [SIZE_ZW-1:0] pln;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] base;
  logic [VW-1:0] center;
  logic [VW-1:0] nb [5];
  logic [2:0] rd_cnt;
  logic [2:0] cap_idx;
  logic [OW-1:0] nb_offset;
  logic [AW-1:0] rd_addr;
  logic rd_en;
  logic [VW-1:0] rdata;
  logic [VW-1:0] in_word;
  logic accept;
  logic col_last, row_last;
  logic res_last;
  logic [DET_W-1:0] res_det;
  logic det_start, det_done;
  logic [DET_W-1:0] det_val;
  logic out_valid;
  logic [DET_W-1:0] out_det;
  logic out_last;

  always_comb begin
    if (size_x < 8'd3) sx = XW'(3);
    else if (32'(size_x) > MAX_X) sx = XW'(MAX_X);
    else sx = XW'(size_x);
    if (size_y < 8'd3) sy = YW'(3);
    else if (32'(size_y) > MAX_Y) sy = YW'(MAX_Y);
    else sy = YW'(size_y);
    sz = (size_z < 16'd3) ? 16'd3 : size_z;
    plane_prod = (XW+YW)'(sx) * (XW+YW)'(sy);
  end

  assign accept   = voxel.valid && voxel.ready;
  assign voxel.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign in_word  = {voxel.vector_z[CB-1:0], voxel.vector_y[CB-1:0],
                     voxel.vector_x[CB-1:0]};
  assign col_last = (XW'(col) == sx - XW'(1));
  assign row_last = (YW'(row) == sy - YW'(1));

  // neighbor distances back from the newest voxel
  always_comb begin
    case (rd_cnt)
      3'd0: nb_offset = plane_q - OW'(1);
      3'd1: nb_offset = plane_q + OW'(1);
      3'd2: nb_offset = plane_q - sx_q;
      3'd3: nb_offset = plane_q + sx_q;
      3'd4: nb_offset = {plane_q[OW-2:0], 1'b0};
      default: nb_offset = '0;
    endcase
    if (OW'(base) >= nb_offset) rd_addr = AW'(OW'(base) - nb_offset);
    else rd_addr = AW'(OW'(base) + OW'(DEPTH) - nb_offset);
    rd_en = (state == S_RD) && (rd_cnt < 3'd5);
    cap_idx = rd_cnt - 3'd1;
  end

  // start once the last neighbor has landed in nb
  assign det_start = (state == S_RD) && (rd_cnt == 3'd6);

  jdf_window #(.DEPTH(DEPTH), .WIDTH(VW)) u_window (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_ptr),
    .wdata (in_word),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  jdf_det #(.COMPONENT_BITS(CB)) u_det (
    .clk   (clk),
    .rst   (rst),
    .start (det_start),
    .xp    (nb[0]),
    .xm    (nb[1]),
    .yp    (nb[2]),
    .ym    (nb[3]),
    .zp    (center),
    .zm    (nb[4]),
    .done  (det_done),
    .det   (det_val)
  );

  assign result.valid          = out_valid;
  assign result.determinant    = out_det;
  assign result.last_of_volume = out_last;

  always_ff @(posedge clk) begin
    plane_q <= OW'(plane_prod);
    sx_q    <= OW'(sx);
    if (rst) begin
      state     <= S_IDLE;
      size_x    <= RST_SIZE_X;
      size_y    <= RST_SIZE_Y;
      size_z    <= RST_SIZE_Z;
      col       <= '0;
      row       <= '0;
      pln       <= '0;
      wr_ptr    <= '0;
      rd_cnt    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        case (cfg.index)
          CFG_SIZE_X: size_x <= cfg.data[SIZE_XW-1:0];
          CFG_SIZE_Y: size_y <= cfg.data[SIZE_YW-1:0];
          CFG_SIZE_Z: size_z <= cfg.data;
          default: ;
        endcase
        col <= '0;
        row <= '0;
        pln <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            base     <= wr_ptr;
            center   <= in_word;
            res_det  <= '0;
            res_last <= col_last && row_last && (pln == sz - 16'd1);
            wr_ptr   <= (32'(wr_ptr) == DEPTH - 1) ? '0 : wr_ptr + AW'(1);
            if (pln != '0) begin
              if (col == '0 || col_last || row == '0 || row_last || pln == 16'd1) begin
                state <= S_OUT;
              end else begin
                rd_cnt <= '0;
                state  <= S_RD;
              end
            end
            if (!cfg.valid) begin
              if (col_last) begin
                col <= '0;
                if (row_last) begin
                  row <= '0;
                  pln <= (17'(pln) + 17'd1 >= 17'(sz)) ? '0 : pln + 16'd1;
                end else begin
                  row <= row + RW'(1);
                end
              end else begin
                col <= col + CW'(1);
              end
            end
          end
        end
        S_RD: begin
          if (rd_cnt != 3'd0 && rd_cnt != 3'd6) begin
            nb[cap_idx] <= rdata;
          end
          if (rd_cnt == 3'd6) begin
            state <= S_CALC;
          end else begin
            rd_cnt <= rd_cnt + 3'd1;
          end
        end
        S_CALC: begin
          if (det_done) begin
            res_det <= det_val;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || result.ready) begin
            out_det   <= res_det;
            out_last  <= res_last;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/jdf_window.sv -----
`timescale 1ns / 1ps
module jdf_window import jdf_pkg::*; #(
  parameter int DEPTH = 2 * DEF_MAX_X * DEF_MAX_Y + 1,
  parameter int WIDTH = 3 * DEF_COMP_BITS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/jdf_det.sv -----
`timescale 1ns / 1ps
module jdf_det import jdf_pkg::*; #(
  parameter int COMPONENT_BITS = DEF_COMP_BITS,
  localparam int CB = COMPONENT_BITS,
  localparam int VW = 3 * CB
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VW-1:0]    xp,
  input  logic [VW-1:0]    xm,
  input  logic [VW-1:0]    yp,
  input  logic [VW-1:0]    ym,
  input  logic [VW-1:0]    zp,
  input  logic [VW-1:0]    zm,
  output logic             done,
  output logic [DET_W-1:0] det
);

  localparam int DW   = CB + 1;
  localparam int MW   = 2 * DW + 1;
  localparam int QW   = DW + MW;
  localparam int SUMW = (QW + 2 > DET_W) ? QW + 2 : DET_W;

  typedef enum logic [2:0] {D_IDLE, D_MUL1, D_MIN, D_MUL2, D_SUM} dstate_t;

  dstate_t state;
  logic [2:0] step;
  logic signed [DW-1:0] jx [3];
  logic signed [DW-1:0] jy [3];
  logic signed [DW-1:0] jz [3];
  logic signed [QW-1:0] p [6];
  logic signed [MW-1:0] m [3];
  logic signed [QW-1:0] q [3];
  logic signed [DW-1:0] ma;
  logic signed [MW-1:0] mb;
  logic signed [QW-1:0] prod;
  logic signed [SUMW-1:0] sum;

  // one shared multiplier: six minor products, then three cofactor products
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == D_MUL1) begin
      case (step)
        3'd0: begin ma = jy[1]; mb = MW'(jz[2]); end
        3'd1: begin ma = jy[2]; mb = MW'(jz[1]); end
        3'd2: begin ma = jx[1]; mb = MW'(jz[2]); end
        3'd3: begin ma = jx[2]; mb = MW'(jz[1]); end
        3'd4: begin ma = jx[1]; mb = MW'(jy[2]); end
        3'd5: begin ma = jx[2]; mb = MW'(jy[1]); end
        default: begin ma = '0; mb = '0; end
      endcase
    end else if (state == D_MUL2) begin
      case (step)
        3'd0: begin ma = jx[0]; mb = m[0]; end
        3'd1: begin ma = jy[0]; mb = m[1]; end
        3'd2: begin ma = jz[0]; mb = m[2]; end
        default: begin ma = '0; mb = '0; end
      endcase
    end
    prod = ma * mb;
    sum = SUMW'(q[0]) - SUMW'(q[1]) + SUMW'(q[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            for (int c = 0; c < 3; c++) begin
              jx[c] <= DW'($signed(xp[c*CB +: CB])) - DW'($signed(xm[c*CB +: CB]));
              jy[c] <= DW'($signed(yp[c*CB +: CB])) - DW'($signed(ym[c*CB +: CB]));
              jz[c] <= DW'($signed(zp[c*CB +: CB])) - DW'($signed(zm[c*CB +: CB]));
            end
            step  <= '0;
            state <= D_MUL1;
          end
        end
        D_MUL1: begin
          p[step] <= prod;
          if (step == 3'd5) begin
            state <= D_MIN;
          end else begin
            step <= step + 3'd1;
          end
        end
        D_MIN: begin
          for (int i = 0; i < 3; i++) begin
            m[i] <= MW'(p[2*i] - p[2*i+1]);
          end
          step  <= '0;
          state <= D_MUL2;
        end
        D_MUL2: begin
          q[step[1:0]] <= prod;
          if (step == 3'd2) begin
            state <= D_SUM;
          end else begin
            step <= step + 3'd1;
          end
        end
        D_SUM: begin
          det   <= sum[DET_W-1:0];
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule
